// ===== src/rle_pkg.sv =====
// Shared types and constants for the ring leader election node.
package rle_pkg;

    localparam int ID_BITS     = 16;
    localparam int ORIGIN_BITS = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int CFG_BITS    = ID_BITS;

    localparam logic CFG_NODE_RANK = 1'b0;
    localparam logic CFG_OWN_ID    = 1'b1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_MSG   = 1'b1;

    localparam logic KIND_NEW_ID = 1'b0;
    localparam logic KIND_LEADER = 1'b1;

    typedef enum logic [1:0] {
        OP_START,
        OP_NEW_ID,
        OP_LEADER
    } op_t;

    typedef struct packed {
        logic                   req_type;
        logic                   msg_kind;
        logic [ID_BITS-1:0]     msg_id;
        logic [ORIGIN_BITS-1:0] msg_origin;
    } in_t;

    typedef struct packed {
        logic                   send_valid;
        logic                   send_kind;
        logic [ID_BITS-1:0]     send_id;
        logic [ORIGIN_BITS-1:0] send_origin;
        logic                   finished;
        logic [ID_BITS-1:0]     leader_value;
    } out_t;

    typedef struct packed {
        op_t                    op;
        logic [ID_BITS-1:0]     msg_id;
        logic [ORIGIN_BITS-1:0] msg_origin;
    } cmd_t;

endpackage

// ===== src/rle_front.sv =====
// Front end: request intake and decode into queue commands.
module rle_front
    import rle_pkg::*;
(
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    input  logic q_full,
    output logic push,
    output cmd_t push_cmd
);

    always_comb
    begin
        push_cmd.msg_id     = in_data.msg_id;
        push_cmd.msg_origin = in_data.msg_origin;
        if (in_data.req_type == REQ_START)
        begin
            push_cmd.op = OP_START;
        end
        else if (in_data.msg_kind == KIND_LEADER)
        begin
            push_cmd.op = OP_LEADER;
        end
        else
        begin
            push_cmd.op = OP_NEW_ID;
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

endmodule

// ===== src/rle_queue.sv =====
// Small command queue between front end and back end.
module rle_queue
    import rle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg;
    logic [QPTR_BITS:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/rle_back.sv =====
// Back end: election state, configuration registers and result register.
module rle_back
    import rle_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic                cmd_ready,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output out_t                out_data
);

    logic [ORIGIN_BITS-1:0] node_rank_reg;
    logic [ID_BITS-1:0]     own_id_reg;

    logic [ID_BITS-1:0] active_id_reg;
    logic [ID_BITS-1:0] active_id_next;
    logic [ID_BITS-1:0] held_first_reg;
    logic [ID_BITS-1:0] held_first_next;
    logic               held_valid_reg;
    logic               held_valid_next;
    logic               relay_reg;
    logic               relay_next;
    logic               done_reg;
    logic               done_next;
    logic [ID_BITS-1:0] leader_reg;
    logic [ID_BITS-1:0] leader_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    out_t               out_data_reg;
    out_t               result;
    logic [ID_BITS-1:0] top_id;

    assign cmd_pop   = cmd_ready && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign top_id    = (active_id_reg > cmd.msg_id) ? active_id_reg : cmd.msg_id;

    always_comb
    begin
        active_id_next  = active_id_reg;
        held_first_next = held_first_reg;
        held_valid_next = held_valid_reg;
        relay_next      = relay_reg;
        done_next       = done_reg;
        leader_next     = leader_reg;
        result          = '0;
        case (cmd.op)
            OP_START:
            begin
                active_id_next     = own_id_reg;
                held_first_next    = '0;
                held_valid_next    = 1'b0;
                relay_next         = 1'b0;
                done_next          = 1'b0;
                leader_next        = '0;
                result.send_valid  = 1'b1;
                result.send_kind   = KIND_NEW_ID;
                result.send_id     = own_id_reg;
            end
            OP_NEW_ID:
            begin
                if (!done_reg)
                begin
                    if (relay_reg)
                    begin
                        result.send_valid  = 1'b1;
                        result.send_kind   = KIND_NEW_ID;
                        result.send_id     = cmd.msg_id;
                        result.send_origin = cmd.msg_origin;
                    end
                    else if (!held_valid_reg)
                    begin
                        held_first_next   = cmd.msg_id;
                        held_valid_next   = 1'b1;
                        result.send_valid = 1'b1;
                        if (cmd.msg_id == active_id_reg)
                        begin
                            result.send_kind   = KIND_LEADER;
                            result.send_id     = active_id_reg;
                            result.send_origin = node_rank_reg;
                        end
                        else
                        begin
                            result.send_kind   = KIND_NEW_ID;
                            result.send_id     = cmd.msg_id;
                            result.send_origin = cmd.msg_origin;
                        end
                    end
                    else if (held_first_reg > top_id)
                    begin
                        active_id_next     = held_first_reg;
                        held_valid_next    = 1'b0;
                        held_first_next    = '0;
                        result.send_valid  = 1'b1;
                        result.send_kind   = KIND_NEW_ID;
                        result.send_id     = held_first_reg;
                        result.send_origin = cmd.msg_origin;
                    end
                    else
                    begin
                        relay_next = 1'b1;
                    end
                end
            end
            OP_LEADER:
            begin
                if (!done_reg)
                begin
                    leader_next = cmd.msg_id;
                    done_next   = 1'b1;
                    if (cmd.msg_origin != node_rank_reg)
                    begin
                        result.send_valid  = 1'b1;
                        result.send_kind   = KIND_LEADER;
                        result.send_id     = cmd.msg_id;
                        result.send_origin = cmd.msg_origin;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
        result.finished     = done_next;
        result.leader_value = leader_next;

        out_valid_next = out_valid_reg;
        if (cmd_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_rank_reg  <= '0;
            own_id_reg     <= '0;
            active_id_reg  <= '0;
            held_first_reg <= '0;
            held_valid_reg <= 1'b0;
            relay_reg      <= 1'b0;
            done_reg       <= 1'b0;
            leader_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_NODE_RANK)
            begin
                node_rank_reg <= cfg_data[ORIGIN_BITS-1:0];
            end
            if (cfg_we && cfg_index == CFG_OWN_ID)
            begin
                own_id_reg <= cfg_data[ID_BITS-1:0];
            end
            if (cmd_pop)
            begin
                active_id_reg  <= active_id_next;
                held_first_reg <= held_first_next;
                held_valid_reg <= held_valid_next;
                relay_reg      <= relay_next;
                done_reg       <= done_next;
                leader_reg     <= leader_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== src/ring_leader_election_node.sv =====
// Top level of one ring leader election node.
//
//   channel   direction  handshake            payload
//   in        request    in_valid/in_stall    in_data  (in_t)
//   out       result     out_valid/out_stall  out_data (out_t)
//   cfg       write      cfg_we               cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; each request yields one result.
// Each request is decoded into a 4-entry queue, then one state update writes
// the result register. The state update is a registered loop in the
// back end, which sets the 1 request per cycle figure.
// Reset clears the queue, election state and configuration; no clearing pass.
// out_stall holds the result register; the queue absorbs up to 4 requests
// before in_stall rises.
module ring_leader_election_node
    import rle_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_t                 in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output out_t                out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    logic      q_push;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;
    logic      q_full;
    logic      q_not_empty;
    logic      q_pop;

    rle_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (push_cmd)
    );

    rle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (pop_cmd)
    );

    rle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_ready (q_not_empty),
        .cmd       (pop_cmd),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== src/rle_checker.sv =====
// Port-level checker for the ring leader election node, with its bind.
module rle_checker
    import rle_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input in_t  in_data,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("request changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.send_valid |->
            out_data.send_kind == KIND_NEW_ID && out_data.send_id == '0 &&
            out_data.send_origin == '0)
        else $error("message fields set with no message sent");

    a_no_leader_early: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.finished |-> out_data.leader_value == '0)
        else $error("leader value reported before the node finished");

    a_done_sends_leader: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.finished && out_data.send_valid |->
            out_data.send_kind == KIND_LEADER)
        else $error("finished node sent a new id message");

endmodule

bind ring_leader_election_node rle_checker u_rle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
